// ----- hw/rtl/hvrt_pkg.sv -----
// Shared types and constants for the resistive torque pipeline.
`timescale 1ns / 1ps
package hvrt_pkg;

   localparam int DegreesPerTurnDefault = 360;
   localparam logic [21:0] DegPerRadQ16 = 22'd3754937;

   localparam logic [2:0] CSR_CLOSED   = 3'd0;
   localparam logic [2:0] CSR_OPEN     = 3'd1;
   localparam logic [2:0] CSR_VISCOUS  = 3'd2;
   localparam logic [2:0] CSR_COULOMB  = 3'd3;
   localparam logic [2:0] CSR_STIFF    = 3'd4;
   localparam logic [2:0] CSR_DAMP     = 3'd5;
   localparam logic [2:0] CSR_SMOOTH   = 3'd6;
   localparam logic [2:0] CSR_LIMIT    = 3'd7;

   // Cell counts of the three cell chains in the pipeline.
   localparam int WallSteps = 6;    // one dividend byte per turn-divide cell
   localparam int SqrtSteps = 32;   // one result bit per root cell
   localparam int DivSteps  = 32;   // one quotient bit per divide cell

   typedef struct packed {
      logic        quiet;
      logic        vneg;
      logic [31:0] wmag;
      logic [63:0] total;   // signed running sum
      logic        wall_on;
      logic        pen_neg;
      logic [32:0] pmag;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [63:0] num;     // coulomb numerator, |vel| * coulomb
      logic [63:0] sum;     // vel^2 + eps^2
      logic [47:0] stiff_n; // stiffness dividend, replaced by quotient bytes
      logic [11:0] stiff_r; // running remainder
      logic [47:0] omt_n;   // turn rate dividend, replaced by quotient bytes
      logic [11:0] omt_r;   // running remainder
   } wall_type;

   typedef struct packed {
      item_type    item;
      logic [63:0] num;     // coulomb numerator, |vel| * coulomb
      logic [63:0] rem;     // sqrt remainder / divide remainder
      logic [63:0] root;    // sqrt root, later divisor
      logic [63:0] quo;     // divide quotient bits
   } cell_type;

endpackage

// ----- hw/rtl/hvrt_root_cell.sv -----
// One step of the bit-pair square root, passed along the chain each cycle.
`timescale 1ns / 1ps
module hvrt_root_cell
   import hvrt_pkg::*;
#(
   parameter int Step = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     v_in,
   input  cell_type c_in,
   output logic     v_out,
   output cell_type c_out
);
   localparam int Shift = 62 - 2 * Step;
   logic [63:0] bit_w;
   logic [63:0] trial;
   cell_type    c_in_w;
   cell_type    c_ff;
   logic        v_ff;

   always_comb begin
      bit_w  = 64'd1 << Shift;
      trial  = c_in.root + bit_w;
      c_in_w = c_in;
      if (c_in.rem >= trial) begin
         c_in_w.rem  = c_in.rem - trial;
         c_in_w.root = (c_in.root >> 1) + bit_w;
      end else begin
         c_in_w.root = c_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      c_ff <= c_in_w;
   end

   assign v_out = v_ff;
   assign c_out = c_ff;
endmodule

// ----- hw/rtl/hvrt_div_cell.sv -----
// Divide steps: the friction quotient and the division by the turn constant.
`timescale 1ns / 1ps
module hvrt_div_cell
   import hvrt_pkg::*;
#(
   parameter int Step = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     v_in,
   input  cell_type c_in,
   output logic     v_out,
   output cell_type c_out
);
   localparam int Bit = 31 - Step;
   logic [63:0] part;
   cell_type    c_next;
   cell_type    c_ff;
   logic        v_ff;

   // rem holds the partial remainder; num holds the dividend.
   always_comb begin
      c_next = c_in;
      part   = {c_in.rem[62:0], c_in.num[Bit]};
      if (c_in.root != 64'd0 && part >= c_in.root) begin
         c_next.rem      = part - c_in.root;
         c_next.quo[Bit] = 1'b1;
      end else begin
         c_next.rem = part;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      c_ff <= c_next;
   end

   assign v_out = v_ff;
   assign c_out = c_ff;
endmodule

// Long division by the turn constant, one dividend byte per cell, most
// significant byte first. The byte quotient comes from a reciprocal product,
// exact while remainder * 256 + byte stays below 256 * TurnDegrees.
module hvrt_turn_cell
   import hvrt_pkg::*;
#(
   parameter int Step        = 0,
   parameter int TurnDegrees = DegreesPerTurnDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     v_in,
   input  wall_type c_in,
   output logic     v_out,
   output wall_type c_out
);
   localparam int Hi = 47 - 8 * Step;
   localparam logic [11:0] Den = 12'(TurnDegrees);
   localparam logic [32:0] Recip =
      33'(((64'd1 << 32) + 64'(TurnDegrees) - 64'd1) / 64'(TurnDegrees));
   logic [19:0] st_t, om_t, st_m, om_m;
   logic [52:0] st_p, om_p;
   wall_type    c_next;
   wall_type    c_ff;
   logic        v_ff;

   always_comb begin
      c_next = c_in;
      st_t   = {c_in.stiff_r, c_in.stiff_n[Hi -: 8]};
      st_p   = 53'(st_t) * 53'(Recip);
      st_m   = 20'(st_p[39:32]) * 20'(Den);
      c_next.stiff_n[Hi -: 8] = st_p[39:32];
      c_next.stiff_r          = 12'(st_t - st_m);
      om_t   = {c_in.omt_r, c_in.omt_n[Hi -: 8]};
      om_p   = 53'(om_t) * 53'(Recip);
      om_m   = 20'(om_p[39:32]) * 20'(Den);
      c_next.omt_n[Hi -: 8] = om_p[39:32];
      c_next.omt_r          = 12'(om_t - om_m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      c_ff <= c_next;
   end

   assign v_out = v_ff;
   assign c_out = c_ff;
endmodule

// ----- hw/rtl/haptic_valve_resistive_torque.sv -----
// Top level: resistive haptic torque with virtual walls and smooth friction.
//
// Usage: pulse start with req_position, req_velocity, req_quiet; busy stays
// low, so a new sample may be started in every clock cycle. Each sample
// yields exactly one torque on rsp_torque, marked by rsp_valid for one
// cycle, in the order the samples came in. The receiver cannot stall.
// From the edge that takes a sample to the edge that takes its torque, the
// sample passes three front stages (magnitudes, products, rounding), six
// cells dividing the wall terms by the turn constant a byte at a time, one
// wall sum stage, 32 root cells for sqrt(v^2+eps^2), one root bit each, 32
// divide cells for the friction quotient, one quotient bit each, then
// rounding, sum and clamp. Throughput is one sample per cycle. Registers are
// written through the csr_ channel (always ready) only while no sample is in
// flight; the user must keep to this, the block does not enforce it. Reset
// clears all valid bits and loads the register defaults; samples in flight
// at reset are dropped.
module haptic_valve_resistive_torque
   import hvrt_pkg::*;
#(
   parameter int TURN_DEGREES = DegreesPerTurnDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_velocity,
   input  logic               req_quiet,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_torque,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam logic [63:0] HalfDen  = 64'(32768 * TURN_DEGREES);
   localparam logic [63:0] PenMin   = 64'(65536 * TURN_DEGREES);

   logic signed [31:0] closed_ff, open_ff;
   logic [30:0] visc_ff, coul_ff, stiff_ff, damp_ff, smooth_ff, limit_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 32'sd0;
         open_ff   <= 32'sd5898240;
         visc_ff   <= '0;
         coul_ff   <= '0;
         stiff_ff  <= '0;
         damp_ff   <= '0;
         smooth_ff <= 31'd6554;
         limit_ff  <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLOSED:  closed_ff <= csr_data;
            CSR_OPEN:    open_ff   <= csr_data;
            CSR_VISCOUS: visc_ff   <= csr_data[30:0];
            CSR_COULOMB: coul_ff   <= csr_data[30:0];
            CSR_STIFF:   stiff_ff  <= csr_data[30:0];
            CSR_DAMP:    damp_ff   <= csr_data[30:0];
            CSR_SMOOTH:  smooth_ff <= csr_data[30:0];
            CSR_LIMIT:   limit_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // ---- front stage 1: magnitudes and penetration
   logic        s1_v_ff;
   item_type    s1_ff, s1_in;
   logic [32:0] left_w, right_w;
   logic signed [33:0] pen_w;

   always_comb begin
      s1_in       = '0;
      s1_in.quiet = req_quiet;
      s1_in.vneg  = req_velocity[31];
      s1_in.wmag  = req_velocity[31] ? 32'(-req_velocity) : req_velocity;
      left_w  = 33'(req_position) - 33'(closed_ff);
      right_w = 33'(req_position) - 33'(open_ff);
      if (!left_w[32]) left_w = '0;
      if (right_w[32]) right_w = '0;
      pen_w = 34'(signed'(left_w)) + 34'(signed'(right_w));
      s1_in.pen_neg = pen_w[33];
      s1_in.pmag    = pen_w[33] ? 33'(-pen_w) : pen_w[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start && !busy;
      end
      s1_ff <= s1_in;
   end

   // ---- stage 2: products
   logic        s2_v_ff;
   item_type    s2_ff, s2_in;
   logic [63:0] vis_p_ff, coul_p_ff, sq_v_ff, sq_e_ff, stiff_p_ff, omt_p_ff;
   logic        wall_in;

   assign wall_in = (64'(s1_ff.pmag) * 64'd1000000) >= PenMin;

   always_comb begin
      s2_in         = s1_ff;
      s2_in.wall_on = wall_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_ff      <= s2_in;
      vis_p_ff   <= 64'(visc_ff) * 64'(s1_ff.wmag);
      coul_p_ff  <= 64'(coul_ff) * 64'(s1_ff.wmag);
      sq_v_ff    <= 64'(s1_ff.wmag) * 64'(s1_ff.wmag);
      sq_e_ff    <= 64'(smooth_ff) * 64'(smooth_ff);
      stiff_p_ff <= 64'(stiff_ff) * 64'(s1_ff.pmag);
      omt_p_ff   <= 64'(s1_ff.wmag) * 64'(DegPerRadQ16);
   end

   // ---- stage 3: viscous term, wall dividends rounded and scaled by 2^-16
   logic        s3_v_ff;
   wall_type    s3_ff, s3_in;
   logic [63:0] vis_r_w, stiff_h_w, omt_h_w;

   always_comb begin
      vis_r_w   = (vis_p_ff + 64'd32768) >> 16;
      stiff_h_w = (stiff_p_ff + HalfDen) >> 16;
      omt_h_w   = (omt_p_ff + HalfDen) >> 16;
      s3_in            = '0;
      s3_in.item       = s2_ff;
      s3_in.item.total = s2_ff.vneg ? vis_r_w : -vis_r_w;
      s3_in.num        = coul_p_ff;
      s3_in.sum        = sq_v_ff + sq_e_ff;
      s3_in.stiff_n    = stiff_h_w[47:0];
      s3_in.omt_n      = omt_h_w[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_ff <= s3_in;
   end

   // ---- turn-divide cells
   logic     wv [0:WallSteps];
   wall_type wc [0:WallSteps];
   assign wv[0] = s3_v_ff;
   assign wc[0] = s3_ff;

   for (genvar g = 0; g < WallSteps; g++) begin : g_wall
      hvrt_turn_cell #(.Step(g), .TurnDegrees(TURN_DEGREES)) u_cell (
         .clock(clock), .reset(reset),
         .v_in(wv[g]), .c_in(wc[g]), .v_out(wv[g+1]), .c_out(wc[g+1]));
   end

   // ---- stage 4: wall damping, partial total
   logic        s4_v_ff;
   cell_type    s4_ff, s4_in;
   wall_type    wl;
   logic [51:0] dmp_hi_w;
   logic [46:0] dmp_lo_w;
   logic [63:0] dmp_w, stiff_w;
   logic signed [63:0] tot_w;

   assign wl = wc[WallSteps];

   always_comb begin
      dmp_hi_w = 52'(damp_ff) * 52'(wl.omt_n[36:16]);
      dmp_lo_w = 47'(damp_ff) * 47'(wl.omt_n[15:0]);
      dmp_w    = 64'(dmp_hi_w) + 64'((dmp_lo_w + 47'd32768) >> 16);
      stiff_w  = 64'(wl.stiff_n);
      tot_w    = signed'(wl.item.total);
      if (wl.item.wall_on) begin
         tot_w = wl.item.pen_neg ? tot_w + signed'(stiff_w)
                                 : tot_w - signed'(stiff_w);
         tot_w = wl.item.vneg ? tot_w + signed'(dmp_w) : tot_w - signed'(dmp_w);
      end
      s4_in            = '0;
      s4_in.item       = wl.item;
      s4_in.item.total = tot_w;
      s4_in.num        = wl.num;
      s4_in.rem        = wl.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= wv[WallSteps];
      end
      s4_ff <= s4_in;
   end

   // ---- square root cells
   logic     rv [0:SqrtSteps];
   cell_type rc [0:SqrtSteps];
   assign rv[0] = s4_v_ff;
   assign rc[0] = s4_ff;

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_root
      hvrt_root_cell #(.Step(g)) u_cell (
         .clock(clock), .reset(reset),
         .v_in(rv[g]), .c_in(rc[g]), .v_out(rv[g+1]), .c_out(rc[g+1]));
   end

   // hand over: root becomes divisor; the quotient is below 2^32 since the
   // root is at least |vel|, so the upper dividend half seeds the remainder
   cell_type dc0;
   always_comb begin
      dc0      = rc[SqrtSteps];
      dc0.rem  = {32'd0, dc0.num[63:32]};
      dc0.quo  = '0;
   end

   logic     dv [0:DivSteps];
   cell_type dc [0:DivSteps];
   assign dv[0] = rv[SqrtSteps];
   assign dc[0] = dc0;

   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      hvrt_div_cell #(.Step(g)) u_cell (
         .clock(clock), .reset(reset),
         .v_in(dv[g]), .c_in(dc[g]), .v_out(dv[g+1]), .c_out(dc[g+1]));
   end

   // ---- final stages: round, sum, clamp
   // Round up when twice the remainder reaches the divisor.
   logic        f1_v_ff;
   item_type    f1_ff;
   logic [63:0] fq_ff;
   cell_type    dl;
   logic        up_w;

   assign dl   = dc[DivSteps];
   assign up_w = dl.root != 64'd0 && ({dl.rem[62:0], 1'b0} >= dl.root);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= dv[DivSteps];
      end
      f1_ff <= dl.item;
      fq_ff <= dl.root == 64'd0 ? 64'd0 : dl.quo + 64'(up_w);
   end

   logic        f2_v_ff;
   logic        f2_q_ff;
   logic signed [63:0] f2_tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else begin
         f2_v_ff <= f1_v_ff;
      end
      f2_q_ff   <= f1_ff.quiet;
      f2_tot_ff <= f1_ff.vneg ? signed'(f1_ff.total) + signed'(fq_ff)
                              : signed'(f1_ff.total) - signed'(fq_ff);
   end

   logic        f3_v_ff;
   logic signed [31:0] f3_t_ff;
   logic signed [63:0] lim_w;
   logic signed [31:0] clamp_w;

   always_comb begin
      lim_w = signed'(64'(limit_ff));
      if (f2_q_ff)               clamp_w = '0;
      else if (f2_tot_ff > lim_w)  clamp_w = 32'(lim_w);
      else if (f2_tot_ff < -lim_w) clamp_w = 32'(-lim_w);
      else                       clamp_w = f2_tot_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_v_ff <= 1'b0;
      end else begin
         f3_v_ff <= f2_v_ff;
      end
      f3_t_ff <= clamp_w;
   end

   assign rsp_valid  = f3_v_ff;
   assign rsp_torque = f3_t_ff;

   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      f2_v_ff && f2_q_ff |=> rsp_torque == 32'sd0)
      else $error("quiet sample produced torque");
   a_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_torque <= signed'(33'(limit_ff)))
                 && (rsp_torque >= -signed'(33'(limit_ff))))
      else $error("torque beyond limit");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      dv[DivSteps] |=> f1_v_ff)
      else $error("sample lost at divider exit");
endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the resistive haptic torque pipeline.
`timescale 1ns / 1ps
module testbench
   import hvrt_pkg::*;
();

   class torque_scoreboard;
      longint          closed_pos, open_pos;
      longint unsigned viscous, coulomb, stiffness, damping, smoothing, limit;
      logic [31:0]     torque_queue[$];
      int              mismatches;

      function new();
         closed_pos = 0;
         open_pos   = 5898240;
         viscous    = 0;
         coulomb    = 0;
         stiffness  = 0;
         damping    = 0;
         smoothing  = 6554;
         limit      = 65536;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            CSR_CLOSED:  closed_pos = longint'(signed'(data));
            CSR_OPEN:    open_pos   = longint'(signed'(data));
            CSR_VISCOUS: viscous    = 64'(data[30:0]);
            CSR_COULOMB: coulomb    = 64'(data[30:0]);
            CSR_STIFF:   stiffness  = 64'(data[30:0]);
            CSR_DAMP:    damping    = 64'(data[30:0]);
            CSR_SMOOTH:  smoothing  = 64'(data[30:0]);
            CSR_LIMIT:   limit      = 64'(data[30:0]);
            default: ;
         endcase
      endfunction

      function longint unsigned round_div(longint unsigned num, longint unsigned den);
         return (num + den / 2) / den;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [31:0] predict_torque(logic signed [31:0] position,
                                           logic signed [31:0] velocity, logic quiet);
         longint          pos, vel, vsign, total, lim, left, right, pen;
         longint unsigned wmag, sum, root, pmag, stiff, omt, damp, dpt;
         if (quiet) return 32'd0;
         dpt   = 64'(DegreesPerTurnDefault);
         pos   = longint'(position);
         vel   = longint'(velocity);
         wmag  = (vel < 0) ? -vel : vel;
         vsign = (vel < 0) ? -64'sd1 : 64'sd1;
         total = -vsign * longint'(round_div(viscous * wmag, 64'd65536));
         sum = wmag * wmag + smoothing * smoothing;
         if (sum != 0) begin
            root = int_sqrt(sum);
            if (root != 0) total -= vsign * longint'(round_div(coulomb * wmag, root));
         end
         left  = pos - closed_pos;
         if (left > 0) left = 0;
         right = pos - open_pos;
         if (right < 0) right = 0;
         pen  = left + right;
         pmag = (pen < 0) ? -pen : pen;
         // drop the whole wall term below one micro-turn of penetration
         if (pmag * 64'd1000000 >= dpt * 64'd65536) begin
            stiff = round_div(stiffness * pmag, 64'd65536 * dpt);
            omt   = round_div(wmag * longint'(DegPerRadQ16), 64'd65536 * dpt);
            damp  = damping * (omt >> 16) + round_div(damping * (omt & 64'hFFFF), 64'd65536);
            total -= (pen < 0) ? -longint'(stiff) : longint'(stiff);
            total -= vsign * longint'(damp);
         end
         lim = limit;
         if (total > lim) total = lim;
         else if (total < -lim) total = -lim;
         return total[31:0];
      endfunction

      function void note_sample(logic signed [31:0] position, logic signed [31:0] velocity,
                                logic quiet);
         torque_queue.push_back(predict_torque(position, velocity, quiet));
      endfunction

      function void check_torque(logic [31:0] torque);
         logic [31:0] want;
         if (torque_queue.size() == 0) begin
            $error("torque: unexpected result %h", torque);
            mismatches++;
            return;
         end
         want = torque_queue.pop_front();
         if (torque !== want) begin
            $error("torque: expected %h, got %h", want, torque);
            mismatches++;
         end
      endfunction
   endclass

   localparam int CycleLimit = 600000;

   logic               clock, reset, start, busy;
   logic signed [31:0] req_position, req_velocity;
   logic               req_quiet, rsp_valid;
   logic signed [31:0] rsp_torque;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   torque_scoreboard sb = new();
   int               idle_pct;
   int unsigned      cycles;

   haptic_valve_resistive_torque u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_position(req_position), .req_velocity(req_velocity), .req_quiet(req_quiet),
      .rsp_valid(rsp_valid), .rsp_torque(rsp_torque),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_torque(rsp_torque);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_sample(logic signed [31:0] position, logic signed [31:0] velocity,
                              logic quiet);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_position <= position;
      req_velocity <= velocity;
      req_quiet    <= quiet;
      do @(posedge clock); while (busy);
      sb.note_sample(position, velocity, quiet);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.torque_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(index, data);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(4))
         0:       return 32'd0;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom_range(32'h4_0000);
         3:       return $urandom_range(32'h100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_value(logic [31:0] anchor);
      case ($urandom_range(5))
         0:       return anchor + $urandom_range(60) - 30;
         1:       return anchor + $urandom_range(32'h40_0000) - 32'h20_0000;
         2:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] stops [2];
      cycles       <= 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_position <= '0;
      req_velocity <= '0;
      req_quiet    <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_CLOSED;
      csr_data     <= '0;
      idle_pct     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults first, then a wall setup for the directed samples
      send_sample(32'sd0, 32'sd0, 1'b0);
      send_sample(32'sd1000, 32'sd65536, 1'b0);
      drain();
      write_csr(CSR_VISCOUS, 32'h0000_8000);
      write_csr(CSR_COULOMB, 32'h0001_0000);
      write_csr(CSR_STIFF, 32'h0100_0000);
      write_csr(CSR_DAMP, 32'h0002_0000);
      write_csr(CSR_SMOOTH, 32'd0);
      write_csr(CSR_LIMIT, 32'h7FFF_FFFF);
      send_sample(32'sd0, 32'sd0, 1'b0);             // zero over zero friction
      send_sample(-32'sd23, 32'sd100, 1'b0);         // just under the micro-turn
      send_sample(-32'sd24, 32'sd100, 1'b0);         // just over it
      send_sample(32'sd5898263, -32'sd100, 1'b0);
      send_sample(32'sd5898264, -32'sd100, 1'b0);
      send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_sample(-32'sd1, -32'sd1, 1'b0);
      drain();
      // swapped stops: both walls active at once
      write_csr(CSR_CLOSED, 32'h7FFF_FFFF);
      write_csr(CSR_OPEN, 32'h8000_0000);
      write_csr(CSR_STIFF, 32'h7FFF_FFFF);
      write_csr(CSR_LIMIT, 32'd0);
      send_sample(32'sd0, 32'sd12345, 1'b0);
      drain();
      write_csr(CSR_LIMIT, 32'h7FFF_FFFF);
      send_sample(32'sd0, 32'sd12345, 1'b0);
      send_sample(32'h8000_0000, -32'sd12345, 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         repeat (4) @(posedge clock);
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 84;
            2: idle_pct = 0;
            default: idle_pct = 24;
         endcase
         stops[0] = (phase == 7) ? 32'h8000_0000 : pick_value(32'd0);
         stops[1] = (phase == 7) ? 32'h7FFF_FFFF : pick_value(32'd5898240);
         if (phase == 5) stops = '{stops[1], stops[0]};
         write_csr(CSR_CLOSED, stops[0]);
         write_csr(CSR_OPEN, stops[1]);
         write_csr(CSR_VISCOUS, pick_gain());
         write_csr(CSR_COULOMB, pick_gain());
         write_csr(CSR_STIFF, pick_gain());
         write_csr(CSR_DAMP, pick_gain());
         write_csr(CSR_SMOOTH, (phase == 2) ? 32'd0 : pick_gain());
         write_csr(CSR_LIMIT, (phase == 6) ? 32'd0 :
                              (phase == 3) ? 32'h7FFF_FFFF : pick_gain());
         for (int n = 0; n < 200; n++) begin
            logic [31:0] anchor;
            anchor = $urandom_range(1) ? stops[0] : stops[1];
            if (n == 100) drain();
            send_sample(pick_value(anchor), pick_value(32'd0), $urandom_range(9) == 0);
         end
      end

      drain();
      repeat (80) @(posedge clock);
      if (sb.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
